/* sv/ptb_pkg.sv */
// Package for the periodic timer bank: types, codes and size constants.
// Used by every module of the block but ptb_ram; depends on nothing.
`default_nettype none

package ptb_pkg;

    localparam int NUM_TIMERS_DEF = 16;
    localparam int COUNT_BITS_DEF = 32;
    localparam int FIELD_BITS     = 32;
    localparam int ID_BITS        = 4;
    localparam int MAX_RESULTS    = 16;
    localparam int RES_CNT_BITS   = 5;
    localparam int CMD_FIFO_DEPTH = 2;
    localparam int S_TDATA_BITS   = 72;
    localparam int S_TUSER_BITS   = 4;
    localparam int M_TDATA_BITS   = 8;

    typedef enum logic [2:0] {
        ACT_SETUP  = 3'd0,
        ACT_START  = 3'd1,
        ACT_STOP   = 3'd2,
        ACT_TICK   = 3'd3,
        ACT_DELETE = 3'd4
    } action_t;

    typedef enum logic [2:0] {
        ST_UNUSED  = 3'd0,
        ST_CREATED = 3'd1,
        ST_RUNNING = 3'd2,
        ST_STOPPED = 3'd3,
        ST_DELETED = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        B_IDLE,
        B_START,
        B_WALK,
        B_FLUSH
    } back_state_t;

    typedef struct packed {
        action_t                 action;
        logic [ID_BITS-1:0]      timer_id;
        logic [FIELD_BITS-1:0]   first_delay;
        logic [FIELD_BITS-1:0]   period;
        logic                    group;
    } cmd_t;

endpackage

`default_nettype wire

/* sv/periodic_timer_bank.sv */
// Top level of the periodic timer bank: front end, command queue and executor.
// Depends on ptb_pkg, ptb_front, ptb_cmd_fifo and ptb_back.
//
//   channel  dir  tdata (low bit up)                        tuser            tlast
//   s_axis   in   timer_id[3:0] first_delay period, pad 72  action[2:0] group  -
//   m_axis   out  expired_timer[3:0], pad 8                 one_shot_done    last
//
// Setup, stop and delete finish in the executor's idle state; start also passes
// through the start state. After issue, a tick walks one timer entry per cycle,
// unless the result side stalls, through the single read port of the parameter
// and count RAMs, then drains the pipeline and flushes the last result.
// Reset marks all timers unused at once; no clearing pass is needed.
// A stalled result side freezes the walk only when a second firing is waiting.
// The input side stalls only while the two-entry command queue is full.
`default_nettype none

module periodic_timer_bank #(
    parameter int NUM_TIMERS = ptb_pkg::NUM_TIMERS_DEF,
    parameter int COUNT_BITS = ptb_pkg::COUNT_BITS_DEF
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    // timer_id[3:0], first_delay[35:4], period[67:36], zero fill
    input  wire logic [ptb_pkg::S_TDATA_BITS-1:0]  s_axis_tdata,
    // action[2:0], group[3]
    input  wire logic [ptb_pkg::S_TUSER_BITS-1:0]  s_axis_tuser,
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    // expired_timer[3:0], zero fill
    output logic      [ptb_pkg::M_TDATA_BITS-1:0]  m_axis_tdata,
    // one_shot_done[0]
    output logic      [0:0]                        m_axis_tuser,
    output logic                                   m_axis_tlast
);

    logic          fifo_full;
    logic          fifo_empty;
    logic          push;
    logic          pop;
    ptb_pkg::cmd_t push_cmd;
    ptb_pkg::cmd_t head_cmd;

    ptb_front #(
        .NUM_TIMERS (NUM_TIMERS)
    ) u_front (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .fifo_full     (fifo_full),
        .push          (push),
        .push_cmd      (push_cmd)
    );

    ptb_cmd_fifo u_cmd_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (fifo_full),
        .pop      (pop),
        .empty    (fifo_empty),
        .head_cmd (head_cmd)
    );

    ptb_back #(
        .NUM_TIMERS (NUM_TIMERS),
        .COUNT_BITS (COUNT_BITS)
    ) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .fifo_empty    (fifo_empty),
        .head_cmd      (head_cmd),
        .pop           (pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

`default_nettype wire

/* sv/ptb_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// Standalone; holds the per-timer stores of the timer bank.
`default_nettype none

module ptb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                                    aclk,
    input  wire logic                                    we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                        wdata,
    input  wire logic                                    re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

/* sv/ptb_front.sv */
// Front end of the timer bank: unpacks an input transfer and drops commands
// that have no effect. Depends on ptb_pkg.
`default_nettype none

module ptb_front #(
    parameter int NUM_TIMERS = ptb_pkg::NUM_TIMERS_DEF
) (
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    input  wire logic [ptb_pkg::S_TDATA_BITS-1:0]  s_axis_tdata,
    input  wire logic [ptb_pkg::S_TUSER_BITS-1:0]  s_axis_tuser,
    input  wire logic                              fifo_full,
    output logic                                   push,
    output ptb_pkg::cmd_t                          push_cmd
);

    logic known;
    logic in_range;
    logic keep;

    always_comb begin
        push_cmd.action      = ptb_pkg::action_t'(s_axis_tuser[2:0]);
        push_cmd.group       = s_axis_tuser[3];
        push_cmd.timer_id    = s_axis_tdata[3:0];
        push_cmd.first_delay = s_axis_tdata[35:4];
        push_cmd.period      = s_axis_tdata[67:36];
        known    = s_axis_tuser[2:0] inside {ptb_pkg::ACT_SETUP, ptb_pkg::ACT_START,
                                              ptb_pkg::ACT_STOP, ptb_pkg::ACT_TICK,
                                              ptb_pkg::ACT_DELETE};
        in_range = (32'(s_axis_tdata[3:0]) < 32'(NUM_TIMERS));
        keep     = known && ((s_axis_tuser[2:0] == ptb_pkg::ACT_TICK) || in_range);
    end

    assign s_axis_tready = !fifo_full;
    assign push          = s_axis_tvalid && !fifo_full && keep;

endmodule

`default_nettype wire

/* sv/ptb_cmd_fifo.sv */
// Short command queue between the front end and the executor.
// Depends on ptb_pkg for the command type.
`default_nettype none

module ptb_cmd_fifo #(
    parameter int DEPTH = ptb_pkg::CMD_FIFO_DEPTH
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          push,
    input  ptb_pkg::cmd_t      push_cmd,
    output logic               full,
    input  wire logic          pop,
    output logic               empty,
    output ptb_pkg::cmd_t      head_cmd
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    ptb_pkg::cmd_t    entries_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign head_cmd = entries_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entries_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

/* sv/ptb_back.sv */
// Executor of the timer bank: runs commands, walks the timers on a tick and
// drives the result register. Depends on ptb_pkg and ptb_ram.
`default_nettype none

module ptb_back #(
    parameter int NUM_TIMERS = ptb_pkg::NUM_TIMERS_DEF,
    parameter int COUNT_BITS = ptb_pkg::COUNT_BITS_DEF
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              fifo_empty,
    input  ptb_pkg::cmd_t                          head_cmd,
    output logic                                   pop,
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    output logic      [ptb_pkg::M_TDATA_BITS-1:0]  m_axis_tdata,
    output logic      [0:0]                        m_axis_tuser,
    output logic                                   m_axis_tlast
);

    localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam int RD_W  = $clog2(NUM_TIMERS + 1);
    localparam int PAR_W = 2 * COUNT_BITS + 1;
    localparam int RC_W  = ptb_pkg::RES_CNT_BITS;

    ptb_pkg::back_state_t state_reg, state_next;
    logic [IDX_W-1:0]     cmd_idx_reg, cmd_idx_next;
    logic                 tick_grp_reg, tick_grp_next;
    logic [RD_W-1:0]      rd_cnt_reg, rd_cnt_next;
    logic                 ex_valid_reg, ex_valid_next;
    logic [IDX_W-1:0]     ex_idx_reg, ex_idx_next;
    logic                 pend_valid_reg, pend_valid_next;
    logic [IDX_W-1:0]     pend_idx_reg, pend_idx_next;
    logic                 pend_one_reg, pend_one_next;
    logic [RC_W-1:0]      res_cnt_reg, res_cnt_next;
    logic                 m_valid_reg, m_valid_next;
    logic [IDX_W-1:0]     m_idx_reg, m_idx_next;
    logic                 m_one_reg, m_one_next;
    logic                 m_last_reg, m_last_next;
    ptb_pkg::status_t     status_reg [NUM_TIMERS];

    logic                 stat_we;
    logic [IDX_W-1:0]     stat_waddr;
    ptb_pkg::status_t     stat_wdata;
    logic [IDX_W-1:0]     stat_raddr;
    ptb_pkg::status_t     stat_rd;

    logic                 rd_en;
    logic [IDX_W-1:0]     rd_addr;
    logic                 par_we;
    logic [PAR_W-1:0]     par_wdata;
    logic [PAR_W-1:0]     par_rdata;
    logic                 rem_we;
    logic [IDX_W-1:0]     rem_waddr;
    logic [COUNT_BITS-1:0] rem_wdata;
    logic [COUNT_BITS-1:0] rem_rdata;

    logic [IDX_W-1:0]      head_idx;
    logic [COUNT_BITS-1:0] head_fd;
    logic [COUNT_BITS-1:0] head_per;
    logic [COUNT_BITS-1:0] p_fd;
    logic [COUNT_BITS-1:0] p_per;
    logic                  p_grp;
    logic                  head_startable;
    logic                  ex_act;
    logic                  ex_fire;
    logic                  want_emit;
    logic                  out_free;
    logic                  stall;
    logic                  rd_more;

    assign head_idx = IDX_W'(head_cmd.timer_id);
    assign head_fd  = head_cmd.first_delay[COUNT_BITS-1:0];
    assign head_per = head_cmd.period[COUNT_BITS-1:0];
    assign p_fd     = par_rdata[COUNT_BITS-1:0];
    assign p_per    = par_rdata[2*COUNT_BITS-1:COUNT_BITS];
    assign p_grp    = par_rdata[PAR_W-1];

    assign stat_raddr     = (state_reg == ptb_pkg::B_WALK) ? ex_idx_reg : head_idx;
    assign stat_rd        = status_reg[stat_raddr];
    assign head_startable = (stat_rd == ptb_pkg::ST_CREATED) ||
                            (stat_rd == ptb_pkg::ST_STOPPED);

    assign ex_act    = ex_valid_reg && (stat_rd == ptb_pkg::ST_RUNNING) &&
                       (p_grp == tick_grp_reg);
    assign ex_fire   = ex_act && (rem_rdata <= COUNT_BITS'(1));
    assign want_emit = ex_fire && (res_cnt_reg != RC_W'(ptb_pkg::MAX_RESULTS));
    assign out_free  = !m_valid_reg || m_axis_tready;
    assign stall     = want_emit && pend_valid_reg && !out_free;
    assign rd_more   = (rd_cnt_reg < RD_W'(NUM_TIMERS));

    ptb_ram #(
        .WIDTH (PAR_W),
        .DEPTH (NUM_TIMERS)
    ) u_param_ram (
        .aclk  (aclk),
        .we    (par_we),
        .waddr (head_idx),
        .wdata (par_wdata),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (par_rdata)
    );

    ptb_ram #(
        .WIDTH (COUNT_BITS),
        .DEPTH (NUM_TIMERS)
    ) u_count_ram (
        .aclk  (aclk),
        .we    (rem_we),
        .waddr (rem_waddr),
        .wdata (rem_wdata),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (rem_rdata)
    );

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ptb_pkg::B_IDLE: begin
                if (!fifo_empty) begin
                    case (head_cmd.action)
                        ptb_pkg::ACT_START: begin
                            if (head_startable) begin
                                state_next = ptb_pkg::B_START;
                            end
                        end
                        ptb_pkg::ACT_TICK: begin
                            state_next = ptb_pkg::B_WALK;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ptb_pkg::B_START: begin
                state_next = ptb_pkg::B_IDLE;
            end
            ptb_pkg::B_WALK: begin
                if (!rd_more && !ex_valid_reg) begin
                    state_next = ptb_pkg::B_FLUSH;
                end
            end
            ptb_pkg::B_FLUSH: begin
                if (!pend_valid_reg || out_free) begin
                    state_next = ptb_pkg::B_IDLE;
                end
            end
            default: begin
                state_next = ptb_pkg::B_IDLE;
            end
        endcase
    end

    always_comb begin
        pop             = 1'b0;
        cmd_idx_next    = cmd_idx_reg;
        tick_grp_next   = tick_grp_reg;
        rd_cnt_next     = rd_cnt_reg;
        ex_valid_next   = ex_valid_reg;
        ex_idx_next     = ex_idx_reg;
        pend_valid_next = pend_valid_reg;
        pend_idx_next   = pend_idx_reg;
        pend_one_next   = pend_one_reg;
        res_cnt_next    = res_cnt_reg;
        m_valid_next    = m_valid_reg && !m_axis_tready;
        m_idx_next      = m_idx_reg;
        m_one_next      = m_one_reg;
        m_last_next     = m_last_reg;
        stat_we         = 1'b0;
        stat_waddr      = head_idx;
        stat_wdata      = ptb_pkg::ST_CREATED;
        rd_en           = 1'b0;
        rd_addr         = head_idx;
        par_we          = 1'b0;
        par_wdata       = {head_cmd.group, head_per, head_fd};
        rem_we          = 1'b0;
        rem_waddr       = head_idx;
        rem_wdata       = (head_fd != '0) ? head_fd : head_per;

        case (state_reg)
            ptb_pkg::B_IDLE: begin
                if (!fifo_empty) begin
                    pop           = 1'b1;
                    cmd_idx_next  = head_idx;
                    tick_grp_next = head_cmd.group;
                    case (head_cmd.action)
                        ptb_pkg::ACT_SETUP: begin
                            par_we     = 1'b1;
                            rem_we     = 1'b1;
                            stat_we    = 1'b1;
                            stat_wdata = ptb_pkg::ST_CREATED;
                        end
                        ptb_pkg::ACT_START: begin
                            rd_en = head_startable;
                        end
                        ptb_pkg::ACT_STOP: begin
                            if (stat_rd == ptb_pkg::ST_RUNNING) begin
                                stat_we    = 1'b1;
                                stat_wdata = ptb_pkg::ST_STOPPED;
                            end
                        end
                        ptb_pkg::ACT_DELETE: begin
                            stat_we    = 1'b1;
                            stat_wdata = ptb_pkg::ST_DELETED;
                        end
                        ptb_pkg::ACT_TICK: begin
                            rd_cnt_next     = '0;
                            ex_valid_next   = 1'b0;
                            res_cnt_next    = '0;
                            pend_valid_next = 1'b0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ptb_pkg::B_START: begin
                rem_we     = 1'b1;
                rem_waddr  = cmd_idx_reg;
                rem_wdata  = (p_fd != '0) ? p_fd : p_per;
                stat_we    = 1'b1;
                stat_waddr = cmd_idx_reg;
                stat_wdata = ptb_pkg::ST_RUNNING;
            end
            ptb_pkg::B_WALK: begin
                if (!stall) begin
                    if (ex_act) begin
                        rem_we    = 1'b1;
                        rem_waddr = ex_idx_reg;
                        rem_wdata = ex_fire ? p_per : (rem_rdata - COUNT_BITS'(1));
                        if (ex_fire && (p_per == '0)) begin
                            stat_we    = 1'b1;
                            stat_waddr = ex_idx_reg;
                            stat_wdata = ptb_pkg::ST_STOPPED;
                        end
                    end
                    if (want_emit) begin
                        if (pend_valid_reg) begin
                            m_valid_next = 1'b1;
                            m_idx_next   = pend_idx_reg;
                            m_one_next   = pend_one_reg;
                            m_last_next  = 1'b0;
                        end
                        pend_valid_next = 1'b1;
                        pend_idx_next   = ex_idx_reg;
                        pend_one_next   = (p_per == '0);
                        res_cnt_next    = res_cnt_reg + RC_W'(1);
                    end
                    if (rd_more) begin
                        rd_en         = 1'b1;
                        rd_addr       = rd_cnt_reg[IDX_W-1:0];
                        ex_valid_next = 1'b1;
                        ex_idx_next   = rd_cnt_reg[IDX_W-1:0];
                        rd_cnt_next   = rd_cnt_reg + RD_W'(1);
                    end else begin
                        ex_valid_next = 1'b0;
                    end
                end
            end
            ptb_pkg::B_FLUSH: begin
                if (pend_valid_reg && out_free) begin
                    m_valid_next    = 1'b1;
                    m_idx_next      = pend_idx_reg;
                    m_one_next      = pend_one_reg;
                    m_last_next     = 1'b1;
                    pend_valid_next = 1'b0;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ptb_pkg::B_IDLE;
            ex_valid_reg   <= 1'b0;
            pend_valid_reg <= 1'b0;
            res_cnt_reg    <= '0;
            rd_cnt_reg     <= '0;
            m_valid_reg    <= 1'b0;
            for (int i = 0; i < NUM_TIMERS; i++) begin
                status_reg[i] <= ptb_pkg::ST_UNUSED;
            end
        end else begin
            state_reg      <= state_next;
            ex_valid_reg   <= ex_valid_next;
            pend_valid_reg <= pend_valid_next;
            res_cnt_reg    <= res_cnt_next;
            rd_cnt_reg     <= rd_cnt_next;
            m_valid_reg    <= m_valid_next;
            if (stat_we) begin
                status_reg[stat_waddr] <= stat_wdata;
            end
        end
    end

    always_ff @(posedge aclk) begin
        cmd_idx_reg  <= cmd_idx_next;
        tick_grp_reg <= tick_grp_next;
        ex_idx_reg   <= ex_idx_next;
        pend_idx_reg <= pend_idx_next;
        pend_one_reg <= pend_one_next;
        m_idx_reg    <= m_idx_next;
        m_one_reg    <= m_one_next;
        m_last_reg   <= m_last_next;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {{(ptb_pkg::M_TDATA_BITS - ptb_pkg::ID_BITS){1'b0}},
                            ptb_pkg::ID_BITS'(m_idx_reg)};
    assign m_axis_tuser  = m_one_reg;
    assign m_axis_tlast  = m_last_reg;

    // A count entry is never read in the cycle it is written.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (rem_we && rd_en) |-> (rem_waddr != rd_addr))
        else $error("count store read and written at the same entry");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ptb_pkg::B_IDLE) |-> !pend_valid_reg)
        else $error("pending result left over after a tick");

    assert property (@(posedge aclk) disable iff (!aresetn)
        res_cnt_reg <= RC_W'(ptb_pkg::MAX_RESULTS))
        else $error("result count above the limit");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ptb_pkg::B_FLUSH && pend_valid_reg && out_free)
        |=> (m_valid_reg && m_last_reg))
        else $error("final result of a tick not marked last");

    assert property (@(posedge aclk) disable iff (!aresetn)
        stall |=> ($stable(ex_idx_reg) && ex_valid_reg))
        else $error("timer entry lost while the result side stalls");

endmodule

`default_nettype wire
